// File: sv/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Shared types, constants and helpers for the frame lag delay line.
// ----------------------------------------------------------------------------
package fld_pkg;

  localparam int FRAME_SLOTS = 16;
  localparam int FRAME_CAP   = 256;
  localparam int SAMPLE_BITS = 24;

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int POS_W  = $clog2(FRAME_CAP);
  localparam int ADDR_W = SLOT_W + POS_W;
  localparam int CNT_W  = 5;   // width of ring depth / lag_frames / stored count
  localparam int LEN_W  = 9;   // width of frame_length / padding length

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_RING_FRAMES  = 3'd0,
    REG_LAG_FRAMES   = 3'd1,
    REG_PAD_VALUE    = 3'd2,
    REG_START_MODE   = 3'd3,
    REG_FRAME_LENGTH = 3'd4
  } reg_idx_t;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_DATA      = 2'd0,
    OP_RESET     = 2'd1,
    OP_RESET_NIL = 2'd2,
    OP_IGNORE    = 2'd3
  } op_t;

  // Where a result sample comes from
  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_FRAME = 2'd1,
    SRC_PAD   = 2'd2,
    SRC_CONST = 2'd3
  } src_t;

  typedef struct packed {
    logic [CNT_W-1:0]       ring_frames;
    logic [CNT_W-1:0]       lag_frames;
    logic [SAMPLE_BITS-1:0] pad_value;
    logic                   start_mode;
    logic [LEN_W-1:0]       frame_length;
  } cfg_t;

  // Clamp ring depth to 1..FRAME_SLOTS
  function automatic logic [CNT_W-1:0] eff_max(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(FRAME_SLOTS)) r = CNT_W'(FRAME_SLOTS);
    return r;
  endfunction

  // Clamp frame length to 1..FRAME_CAP
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(FRAME_CAP)) r = LEN_W'(FRAME_CAP);
    return r;
  endfunction

endpackage

// File: sv/fld_regs.sv
// ----------------------------------------------------------------------------
// fld_regs
// APB register bank; flags a ring clear on writes to the depth or length.
// ----------------------------------------------------------------------------
module fld_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fld_pkg::APB_AW-1:0]    paddr,
  input  logic [fld_pkg::APB_DW-1:0]    pwdata,
  output logic [fld_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output fld_pkg::cfg_t                 cfg,
  output logic                          ring_clear
);

  logic                       wr_en;
  logic [2:0]                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  assign ring_clear = wr_en &&
                      (idx == fld_pkg::REG_RING_FRAMES || idx == fld_pkg::REG_FRAME_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_frames  <= fld_pkg::CNT_W'(10);
      cfg.lag_frames   <= fld_pkg::CNT_W'(1);
      cfg.pad_value    <= '0;
      cfg.start_mode   <= 1'b0;
      cfg.frame_length <= fld_pkg::LEN_W'(64);
    end else if (wr_en) begin
      case (idx)
        fld_pkg::REG_RING_FRAMES:  cfg.ring_frames  <= pwdata[fld_pkg::CNT_W-1:0];
        fld_pkg::REG_LAG_FRAMES:   cfg.lag_frames   <= pwdata[fld_pkg::CNT_W-1:0];
        fld_pkg::REG_PAD_VALUE:    cfg.pad_value    <= pwdata[fld_pkg::SAMPLE_BITS-1:0];
        fld_pkg::REG_START_MODE:   cfg.start_mode   <= pwdata[0];
        fld_pkg::REG_FRAME_LENGTH: cfg.frame_length <= pwdata[fld_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      fld_pkg::REG_RING_FRAMES:
        prdata = fld_pkg::APB_DW'(cfg.ring_frames);
      fld_pkg::REG_LAG_FRAMES:
        prdata = fld_pkg::APB_DW'(cfg.lag_frames);
      fld_pkg::REG_PAD_VALUE:
        prdata = fld_pkg::APB_DW'(cfg.pad_value);
      fld_pkg::REG_START_MODE:
        prdata = fld_pkg::APB_DW'(cfg.start_mode);
      fld_pkg::REG_FRAME_LENGTH:
        prdata = fld_pkg::APB_DW'(cfg.frame_length);
      default:
        prdata = '0;
    endcase
  end

endmodule

// File: sv/frame_lag_delay_line_core.sv
// ----------------------------------------------------------------------------
// frame_lag_delay_line_core
// Frame delay line: a ring of stored frames in one synchronous memory plus a
// padding frame memory; one data sample in gives one lagged sample out.
// ----------------------------------------------------------------------------
// Path: a data sample is read from memory at the edge that accepts it, held in
//   stage 1, and shows its result on m_* from the output register.
// Throughput: one transaction per cycle while m_* is not stalled, set by the
//   single read and write ports of the frame memory, used once per data sample.
// Reset: clears counters, positions, padding length and pipeline valids;
//   the frame and padding memories keep their contents, no clearing pass.
// ----------------------------------------------------------------------------
module frame_lag_delay_line_core (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [fld_pkg::SAMPLE_BITS-1:0]    s_tdata,  // [23:0] sample
  input  logic [1:0]                         s_tuser,  // [1:0] operation
  input  logic                               s_tlast,  // reset_last
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [fld_pkg::SAMPLE_BITS-1:0]    m_tdata,  // [23:0] delayed_sample
  output logic                               m_tuser,  // [0] underlength
  output logic                               m_tlast,  // frame_end
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fld_pkg::APB_AW-1:0]         paddr,
  input  logic [fld_pkg::APB_DW-1:0]         pwdata,
  output logic [fld_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int SW  = fld_pkg::SAMPLE_BITS;
  localparam int SLW = fld_pkg::SLOT_W;
  localparam int PW  = fld_pkg::POS_W;
  localparam int AW  = fld_pkg::ADDR_W;
  localparam int CW  = fld_pkg::CNT_W;
  localparam int LW  = fld_pkg::LEN_W;

  // --------------------------------------------------------------------------
  // Register bank
  // --------------------------------------------------------------------------
  fld_pkg::cfg_t cfg;
  logic          ring_clear;

  fld_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .ring_clear (ring_clear)
  );

  // --------------------------------------------------------------------------
  // Ring state
  // --------------------------------------------------------------------------
  logic [SLW-1:0] write_slot;
  logic [CW-1:0]  stored_count;
  logic [PW-1:0]  sample_position;
  logic [LW-1:0]  reset_position;
  logic [LW-1:0]  padding_length;

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s1_move;
  logic accept;
  logic acc_data;
  logic acc_reset;
  logic acc_nil;

  // Stage 1 drains into the output register when that is empty or being taken
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;
  assign acc_data  = accept && (s_tuser == fld_pkg::OP_DATA);
  assign acc_reset = accept && (s_tuser == fld_pkg::OP_RESET);
  assign acc_nil   = accept && (s_tuser == fld_pkg::OP_RESET_NIL);

  // --------------------------------------------------------------------------
  // Lag selection and addressing, all from current state
  // --------------------------------------------------------------------------
  logic [CW-1:0]  mf;
  logic [LW-1:0]  len;
  logic [CW-1:0]  lag;
  logic [CW-1:0]  n_back;
  logic [CW:0]    slot_sum;
  logic [CW:0]    slot_mod;
  logic [AW-1:0]  frame_rd_addr;
  logic [AW-1:0]  frame_wr_addr;
  logic           frame_end_c;
  logic           under_c;
  logic           pad_hit;
  fld_pkg::src_t  src_c;
  logic [SLW-1:0] slot_inc;

  always_comb begin
    mf  = fld_pkg::eff_max(cfg.ring_frames);
    len = fld_pkg::eff_len(cfg.frame_length);
    lag = (cfg.lag_frames < mf) ? cfg.lag_frames : mf;
    under_c = lag > stored_count;
    // shorten mode: never reach further back than what is stored
    n_back = (cfg.start_mode && under_c) ? stored_count : lag;

    // slot n_back frames behind the write slot, modulo the ring depth
    slot_sum = (CW+1)'(write_slot) + {1'b0, mf} - {1'b0, n_back};
    slot_mod = (slot_sum >= {1'b0, mf}) ? slot_sum - {1'b0, mf} : slot_sum;

    frame_rd_addr = {slot_mod[SLW-1:0], sample_position};
    frame_wr_addr = {write_slot, sample_position};

    frame_end_c = ((LW'(sample_position) + LW'(1)) >= len);
    pad_hit     = LW'(sample_position) < padding_length;

    if (n_back == '0)
      src_c = fld_pkg::SRC_INPUT;
    else if (n_back <= stored_count)
      src_c = fld_pkg::SRC_FRAME;
    else if (pad_hit)
      src_c = fld_pkg::SRC_PAD;
    else
      src_c = fld_pkg::SRC_CONST;

    // advance the write slot, wrapping at the ring depth
    if ((CW'(write_slot) + CW'(1)) >= mf)
      slot_inc = '0;
    else
      slot_inc = write_slot + SLW'(1);
  end

  // --------------------------------------------------------------------------
  // Memories: read-first, so a read of the slot being overwritten at the same
  // edge returns the older frame, as the full-ring lag requires.
  // --------------------------------------------------------------------------
  logic [SW-1:0] frame_mem [2**AW];
  logic [SW-1:0] pad_mem   [2**PW];
  logic [SW-1:0] frame_rdata;
  logic [SW-1:0] pad_rdata;

  always_ff @(posedge clk) begin
    if (acc_data) begin
      frame_rdata <= frame_mem[frame_rd_addr];
      frame_mem[frame_wr_addr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_data) begin
      pad_rdata <= pad_mem[sample_position];
    end
    // drop reset-frame samples past the frame capacity
    if (acc_reset && !reset_position[LW-1]) begin
      pad_mem[reset_position[PW-1:0]] <= s_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // State update
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      stored_count    <= '0;
      sample_position <= '0;
      reset_position  <= '0;
      padding_length  <= '0;
    end else if (ring_clear) begin
      write_slot      <= '0;
      stored_count    <= '0;
      sample_position <= '0;
    end else if (acc_data) begin
      if (frame_end_c) begin
        sample_position <= '0;
        write_slot      <= slot_inc;
        if (stored_count < mf) stored_count <= stored_count + CW'(1);
      end else begin
        sample_position <= sample_position + PW'(1);
      end
    end else if (acc_reset) begin
      write_slot      <= '0;
      stored_count    <= '0;
      sample_position <= '0;
      if (!reset_position[LW-1]) begin
        padding_length <= reset_position + LW'(1);
      end
      // last sample restarts the next padding frame at position zero
      if (s_tlast)
        reset_position <= '0;
      else if (!reset_position[LW-1])
        reset_position <= reset_position + LW'(1);
    end else if (acc_nil) begin
      write_slot      <= '0;
      stored_count    <= '0;
      sample_position <= '0;
      padding_length  <= '0;
      reset_position  <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: hold the choice while memory data comes back
  // --------------------------------------------------------------------------
  fld_pkg::src_t s1_src;
  logic [SW-1:0] s1_value;
  logic          s1_under;
  logic          s1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc_data) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_data) begin
      s1_src   <= src_c;
      s1_value <= (src_c == fld_pkg::SRC_INPUT) ? s_tdata : cfg.pad_value;
      s1_under <= under_c;
      s1_end   <= frame_end_c;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [SW-1:0] s1_sample;

  always_comb begin
    case (s1_src)
      fld_pkg::SRC_FRAME: s1_sample = frame_rdata;
      fld_pkg::SRC_PAD:   s1_sample = pad_rdata;
      default:            s1_sample = s1_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= s1_sample;
      m_tuser <= s1_under;
      m_tlast <= s1_end;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The ring never claims more frames than it can hold
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    stored_count <= fld_pkg::eff_max(cfg.ring_frames))
    else $error("stored frame count exceeds ring depth");

  // The write slot stays inside the ring
  a_slot_bound : assert property (@(posedge clk) disable iff (rst)
    CW'(write_slot) < fld_pkg::eff_max(cfg.ring_frames))
    else $error("write slot outside ring");

  // The position within a frame stays below the frame length
  a_pos_bound : assert property (@(posedge clk) disable iff (rst)
    LW'(sample_position) < fld_pkg::eff_len(cfg.frame_length))
    else $error("sample position beyond frame length");

  // A stalled stage 1 must block new input, or its memory data would be lost
  a_stall_blocks : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while stage 1 is stalled");

endmodule

// File: dv/tb_frame_lag_delay_line_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_lag_delay_line_core
// Self-checking bench for the frame lag delay line. A cycle-free model of the
// ring and padding stores predicts every lagged sample; stimulus covers
// directed corners, register extremes, random streams with idling on both
// sides, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_frame_lag_delay_line_core;

  localparam int SW         = fld_pkg::SAMPLE_BITS;
  localparam int SLOTS      = 16;
  localparam int CAP        = 256;
  localparam int SETTLE_CYC = 4;   // two-stage pipeline plus margin
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          underlength;
    logic          frame_end;
  } lagged_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [SW-1:0]                 s_tdata  = '0;
  logic [1:0]                    s_tuser  = '0;
  logic                          s_tlast  = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [SW-1:0]                 m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [fld_pkg::APB_AW-1:0]    paddr    = '0;
  logic [fld_pkg::APB_DW-1:0]    pwdata   = '0;
  logic [fld_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  frame_lag_delay_line_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [23:0] sample
    .s_tuser  (s_tuser),   // [1:0] operation
    .s_tlast  (s_tlast),   // reset_last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [23:0] delayed_sample
    .m_tuser  (m_tuser),   // [0] underlength
    .m_tlast  (m_tlast),   // frame_end
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Lag model: its own copy of the stores, counters and registers
  // --------------------------------------------------------------------------
  logic [SW-1:0]          ring_mem [0:SLOTS*CAP-1];
  logic [SW-1:0]          pad_mem  [0:CAP-1];
  int unsigned            pad_len;
  int unsigned            wr_slot;
  int unsigned            n_stored;
  int unsigned            cur_pos;
  int unsigned            load_pos;

  logic [4:0]             reg_max;
  logic [4:0]             reg_lag;
  logic [SW-1:0]          reg_pad;
  logic                   reg_shorten;
  logic [8:0]             reg_len;

  lagged_t lagged_q [$];   // predicted output transactions, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int err_count     = 0;

  function automatic int unsigned ring_depth();
    if (reg_max == 5'd0) return 1;
    if (reg_max > 5'(SLOTS)) return SLOTS;
    return reg_max;
  endfunction

  function automatic int unsigned frame_len();
    if (reg_len == 9'd0) return 1;
    if (reg_len > 9'(CAP)) return CAP;
    return reg_len;
  endfunction

  function automatic void empty_ring();
    wr_slot  = 0;
    n_stored = 0;
    cur_pos  = 0;
  endfunction

  // Advance the model by one accepted input transaction
  function automatic void advance_model(fld_pkg::op_t op, logic [SW-1:0] smp,
                                        logic last);
    int unsigned depth;
    int unsigned len;
    int unsigned lag;
    int unsigned n;
    int unsigned pos;
    lagged_t     res;
    case (op)
      fld_pkg::OP_RESET: begin
        empty_ring();
        // samples beyond the padding capacity are dropped
        if (load_pos < CAP) begin
          pad_mem[load_pos] = smp;
          load_pos++;
          pad_len = load_pos;
        end
        if (last) load_pos = 0;
      end
      fld_pkg::OP_RESET_NIL: begin
        empty_ring();
        pad_len  = 0;
        load_pos = 0;
      end
      fld_pkg::OP_DATA: begin
        depth = ring_depth();
        len   = frame_len();
        lag   = (reg_lag < depth) ? reg_lag : depth;
        n     = lag;
        pos   = (cur_pos < CAP) ? cur_pos : CAP - 1;
        if (reg_shorten && n > n_stored) n = n_stored;
        if (n == 0)
          res.sample = smp;
        else if (n <= n_stored)
          res.sample = ring_mem[((wr_slot + depth - n) % depth) * CAP + pos];
        else if (pos < pad_len)
          res.sample = pad_mem[pos];
        else
          res.sample = reg_pad;
        res.underlength = (lag > n_stored);
        res.frame_end   = (pos + 1 >= len);
        lagged_q.push_back(res);
        ring_mem[(wr_slot % SLOTS) * CAP + pos] = smp;
        if (pos + 1 >= len) begin
          cur_pos = 0;
          wr_slot = (wr_slot + 1) % depth;
          if (n_stored < depth) n_stored++;
        end else begin
          cur_pos = pos + 1;
        end
      end
      default: ;  // unknown operation: nothing changes
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and output checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  lagged_t oldest;

  // Compare each output transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (lagged_q.size() == 0) begin
        report_mismatch("unexpected output", {8'd0, m_tdata}, 32'd0);
      end else begin
        oldest = lagged_q.pop_front();
        if (m_tdata !== oldest.sample)
          report_mismatch("delayed_sample", {8'd0, m_tdata}, {8'd0, oldest.sample});
        if (m_tuser !== oldest.underlength)
          report_mismatch("underlength", {31'd0, m_tuser}, {31'd0, oldest.underlength});
        if (m_tlast !== oldest.frame_end)
          report_mismatch("frame_end", {31'd0, m_tlast}, {31'd0, oldest.frame_end});
      end
    end
  end

  // Output side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(fld_pkg::op_t op, logic [SW-1:0] smp, logic last);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = smp;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    advance_model(op, smp, last);
  endtask

  // Drop valid, wait for every predicted output, then let the pipeline settle
  task automatic drain_outputs();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (lagged_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Two-phase register write; only called while the block is idle
  task automatic write_reg(fld_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      fld_pkg::REG_RING_FRAMES:  begin reg_max = value[4:0]; empty_ring(); end
      fld_pkg::REG_LAG_FRAMES:   reg_lag = value[4:0];
      fld_pkg::REG_PAD_VALUE:    reg_pad = value[SW-1:0];
      fld_pkg::REG_START_MODE:   reg_shorten = value[0];
      fld_pkg::REG_FRAME_LENGTH: begin reg_len = value[8:0]; empty_ring(); end
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_regs(logic [4:0] depth, logic [4:0] lag, logic [23:0] pad,
                          logic shorten, logic [8:0] len);
    write_reg(fld_pkg::REG_RING_FRAMES, {27'd0, depth});
    write_reg(fld_pkg::REG_LAG_FRAMES, {27'd0, lag});
    write_reg(fld_pkg::REG_PAD_VALUE, {8'd0, pad});
    write_reg(fld_pkg::REG_START_MODE, {31'd0, shorten});
    write_reg(fld_pkg::REG_FRAME_LENGTH, {23'd0, len});
  endtask

  task automatic send_data(int count);
    repeat (count)
      send_item(fld_pkg::OP_DATA, SW'($urandom()), 1'($urandom_range(1)));
  endtask

  // Load a padding frame; terminated frames set the last flag on their end
  task automatic load_padding(int count, bit terminated);
    for (int i = 0; i < count; i++)
      send_item(fld_pkg::OP_RESET, SW'($urandom()), terminated && (i == count - 1));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corner samples, every operation, padding and shortening from a clean ring
  task automatic test_directed();
    set_regs(5'd2, 5'd1, 24'h7FFFFF, 1'b0, 9'd3);
    send_item(fld_pkg::OP_RESET_NIL, 24'h000000, 1'b0);
    // no padding frame: pad value fills the first frame
    send_item(fld_pkg::OP_DATA, 24'h800000, 1'b0);
    send_item(fld_pkg::OP_DATA, 24'h7FFFFF, 1'b1);   // last flag ignored on data
    send_item(fld_pkg::OP_DATA, 24'h000000, 1'b0);
    send_item(fld_pkg::OP_IGNORE, 24'hFFFFFF, 1'b1);
    send_item(fld_pkg::OP_DATA, 24'hFFFFFF, 1'b0);
    send_item(fld_pkg::OP_DATA, 24'h555555, 1'b0);
    send_item(fld_pkg::OP_DATA, 24'hAAAAAA, 1'b0);
    // two-sample padding frame: positions beyond it take the pad value
    send_item(fld_pkg::OP_RESET, 24'h7FFFFF, 1'b0);
    send_item(fld_pkg::OP_RESET, 24'h800000, 1'b1);
    send_data(6);
    drain_outputs();
    // shorten mode on an empty ring passes input straight through
    set_regs(5'd4, 5'd3, 24'h800000, 1'b1, 9'd2);
    send_data(8);
    send_item(fld_pkg::OP_IGNORE, 24'h000000, 1'b0);
    drain_outputs();
  endtask

  // Full-length padding frame with overflow, then the longest data frames
  task automatic test_long_frames();
    set_regs(5'd31, 5'd1, 24'h123456, 1'b0, 9'd511);
    load_padding(CAP + 2, 1'b1);
    send_data(2 * CAP);
    drain_outputs();
  endtask

  // Deepest ring, clamped lag, pass-through lag and single-slot ring
  task automatic test_ring_extremes();
    set_regs(5'd31, 5'd31, 24'h800000, 1'b0, 9'd0);
    send_data(40);
    drain_outputs();
    set_regs(5'd16, 5'd16, 24'h7FFFFF, 1'b1, 9'd1);
    send_data(24);
    drain_outputs();
    set_regs(5'd5, 5'd0, 24'h000000, 1'b0, 9'd3);
    send_data(8);
    drain_outputs();
    set_regs(5'd0, 5'd5, 24'hFFFFFF, 1'b0, 9'd2);
    send_data(8);
    drain_outputs();
  endtask

  // Random registers, mostly short frames so the ring fills and wraps
  task automatic random_regs();
    logic [8:0] len;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 85)      len = 9'($urandom_range(1, 8));
    else if (pick < 92) len = 9'd0;
    else                len = 9'($urandom_range(9, 40));
    set_regs(5'($urandom_range(31)), 5'($urandom_range(31)), 24'($urandom()),
             1'($urandom_range(1)), len);
  endtask

  // Mostly data with occasional padding frames; noise and broken frames too
  task automatic random_stream(int count);
    int done;
    int pick;
    int n;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 86) begin
        send_data(1);
        done++;
      end else if (pick < 91) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        load_padding(n, 1'b1);
        done += n;
      end else if (pick < 94) begin
        send_item(fld_pkg::OP_RESET_NIL, SW'($urandom()), 1'($urandom_range(1)));
        done++;
      end else if (pick < 97) begin
        send_item(fld_pkg::OP_IGNORE, SW'($urandom()), 1'($urandom_range(1)));
      end else begin
        n = $urandom_range(1, 4);
        load_padding(n, 1'b0);   // frame left open
        done += n;
      end
    end
  endtask

  task automatic test_random();
    int phase;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 18; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (3) begin
        random_regs();
        random_stream(110);
        drain_outputs();
      end
    end
  endtask

  // Hold the output off long enough that the input stalls, then pause input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(5'd4, 5'd2, 24'h2AAAAA, 1'b0, 9'd5);
    @(posedge clk);
    hold_left = 300;
    send_data(120);
    drain_outputs();
    send_data(30);
    drain_outputs();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    pad_len     = 0;
    load_pos    = 0;
    empty_ring();
    reg_max     = 5'd10;
    reg_lag     = 5'd1;
    reg_pad     = '0;
    reg_shorten = 1'b0;
    reg_len     = 9'd64;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_long_frames();
    test_ring_extremes();
    test_random();
    test_backpressure();
    drain_outputs();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: frame_lag_delay_line_core.f
sv/fld_pkg.sv
sv/fld_regs.sv
sv/frame_lag_delay_line_core.sv
dv/tb_frame_lag_delay_line_core.sv
